// ===== design/dll_pkg.sv =====
// ============================================================================
// dll_pkg
// Shared types and constants for the doubly linked list manager.
// ============================================================================
`default_nettype none

package dll_pkg;

    localparam int NODE_W         = 6;
    localparam int KIND_W         = 2;
    localparam int DLL_NODE_COUNT = 64;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SHIFT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

    typedef logic [NODE_W-1:0] node_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        node_t             node;
    } dll_req_t;

    typedef struct packed {
        node_t shifted_node;
        logic  is_queued;
        logic  pending;
    } dll_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic exec;
    } dll_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic tgt_ok;
    } dll_stat_t;

endpackage

`default_nettype wire

// ===== design/doubly_linked_list_manager_top.sv =====
// ============================================================================
// doubly_linked_list_manager_top
// Intrusive doubly linked list over numbered nodes (node 0 is null).
// ============================================================================
// Sequence: the accepting edge loads the request, READ reads the link RAMs,
//   EXEC updates the list and registers the result; READ is skipped when the
//   target is null, out of range, or a shift finds the list empty.
// Requests: a new one is not taken before the last is through; busy covers the
//   link read cycle and the execute cycle, set by the registered read of the RAMs.
// Reset: list empty at once; link entries carry valid flops cleared by reset,
//   so no clearing pass. The receiver cannot stall: done lasts one cycle.
// ============================================================================
`default_nettype none

module doubly_linked_list_manager_top
    import dll_pkg::*;
#(
    parameter int NODE_COUNT = DLL_NODE_COUNT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    // request side: transfer when start is high and busy is low
    input  wire logic     start,
    input  wire dll_req_t request,
    output logic          busy,
    // result side: one transfer per request, done is a single-cycle strobe
    output logic          done,
    output dll_rsp_t      result
);

    dll_cmd_t  cmd;
    dll_stat_t stat;

    // FSM: IDLE -> READ (link lookup of target) -> EXEC (update, result); READ skipped for an invalid target
    dll_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // head, forward/backward link RAMs, valid bits, result register
    dll_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== design/dll_ram.sv =====
// ============================================================================
// dll_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
`default_nettype none

module dll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/dll_ctrl.sv =====
// ============================================================================
// dll_ctrl
// Sequencer: accept, link read, execute.
// ============================================================================
`default_nettype none

module dll_ctrl
    import dll_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire dll_stat_t stat,
    output dll_cmd_t       cmd,
    output logic           busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    // nothing to look up for a null or out-of-range target
                    state_next = stat.tgt_ok ? ST_READ : ST_EXEC;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ===== design/dll_datapath.sv =====
// ============================================================================
// dll_datapath
// Head register, link RAMs with per-entry valid bits, result register.
// ============================================================================
`default_nettype none

module dll_datapath
    import dll_pkg::*;
#(
    parameter int NODE_COUNT = DLL_NODE_COUNT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dll_cmd_t cmd,
    input  wire dll_req_t request,
    output dll_stat_t     stat,
    output logic          done,
    output dll_rsp_t      result
);

    localparam int TBL_DEPTH = (NODE_COUNT < (1 << NODE_W)) ? NODE_COUNT : (1 << NODE_W);
    localparam int ADDR_W    = $clog2(TBL_DEPTH);

    logic [KIND_W-1:0]    kind_reg;
    node_t                tgt_reg;
    logic                 tgt_ok_reg;
    node_t                head_reg;
    node_t                head_next;
    logic [TBL_DEPTH-1:0] fwd_vld_reg;
    logic [TBL_DEPTH-1:0] fwd_vld_next;
    logic [TBL_DEPTH-1:0] bwd_vld_reg;
    logic [TBL_DEPTH-1:0] bwd_vld_next;
    logic                 done_reg;
    dll_rsp_t             rsp_reg;

    node_t                req_tgt;
    logic                 req_tgt_ok;
    logic [ADDR_W-1:0]    addr;
    node_t                fwd_rdata;
    node_t                bwd_rdata;
    node_t                fl;
    node_t                bl;
    logic                 queued;

    logic                 fwd_we;
    logic [ADDR_W-1:0]    fwd_waddr;
    node_t                fwd_wdata;
    logic                 bwd_we;
    logic [ADDR_W-1:0]    bwd_waddr;
    node_t                bwd_wdata;

    node_t                shifted;
    logic                 is_q;

    // shift operates on the current head
    assign req_tgt    = (request.kind == KIND_SHIFT) ? head_reg : request.node;
    assign req_tgt_ok = (req_tgt != '0) && (int'(req_tgt) < NODE_COUNT);
    assign stat.tgt_ok = req_tgt_ok;

    assign addr = tgt_reg[ADDR_W-1:0];

    dll_ram #(
        .WIDTH (NODE_W),
        .DEPTH (TBL_DEPTH)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .re    (cmd.rd),
        .raddr (addr),
        .rdata (fwd_rdata)
    );

    dll_ram #(
        .WIDTH (NODE_W),
        .DEPTH (TBL_DEPTH)
    ) u_bwd_ram (
        .clk   (clk),
        .we    (bwd_we),
        .waddr (bwd_waddr),
        .wdata (bwd_wdata),
        .re    (cmd.rd),
        .raddr (addr),
        .rdata (bwd_rdata)
    );

    // entries never written since reset, or cleared, read as null
    assign fl     = fwd_vld_reg[addr] ? fwd_rdata : '0;
    assign bl     = bwd_vld_reg[addr] ? bwd_rdata : '0;
    assign queued = tgt_ok_reg && ((head_reg == tgt_reg) || (fl != '0) || (bl != '0));

    always_comb
    begin
        head_next    = head_reg;
        fwd_vld_next = fwd_vld_reg;
        bwd_vld_next = bwd_vld_reg;
        fwd_we       = 1'b0;
        fwd_waddr    = addr;
        fwd_wdata    = '0;
        bwd_we       = 1'b0;
        bwd_waddr    = addr;
        bwd_wdata    = '0;
        shifted      = '0;
        is_q         = 1'b0;
        if (cmd.exec)
        begin
            unique case (kind_reg) inside
                KIND_INSERT:
                begin
                    if (tgt_ok_reg && !queued)
                    begin
                        fwd_we             = 1'b1;
                        fwd_wdata          = head_reg;
                        fwd_vld_next[addr] = 1'b1;
                        if (head_reg != '0)
                        begin
                            bwd_we    = 1'b1;
                            bwd_waddr = head_reg[ADDR_W-1:0];
                            bwd_wdata = tgt_reg;
                            bwd_vld_next[head_reg[ADDR_W-1:0]] = 1'b1;
                        end
                        head_next = tgt_reg;
                    end
                end
                KIND_REMOVE, KIND_SHIFT:
                begin
                    if (tgt_ok_reg)
                    begin
                        if (tgt_reg == head_reg)
                        begin
                            head_next = fl;
                            if (fl != '0)
                            begin
                                bwd_vld_next[fl[ADDR_W-1:0]] = 1'b0;
                            end
                        end
                        else
                        begin
                            if (bl != '0)
                            begin
                                fwd_we    = 1'b1;
                                fwd_waddr = bl[ADDR_W-1:0];
                                fwd_wdata = fl;
                                fwd_vld_next[bl[ADDR_W-1:0]] = 1'b1;
                            end
                            if (fl != '0)
                            begin
                                bwd_we    = 1'b1;
                                bwd_waddr = fl[ADDR_W-1:0];
                                bwd_wdata = bl;
                                bwd_vld_next[fl[ADDR_W-1:0]] = 1'b1;
                            end
                        end
                        fwd_vld_next[addr] = 1'b0;
                        bwd_vld_next[addr] = 1'b0;
                        if (kind_reg == KIND_SHIFT)
                        begin
                            shifted = tgt_reg;
                        end
                    end
                end
                KIND_QUERY:
                begin
                    is_q = queued;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= KIND_INSERT;
            tgt_reg     <= '0;
            tgt_ok_reg  <= 1'b0;
            head_reg    <= '0;
            fwd_vld_reg <= '0;
            bwd_vld_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg   <= request.kind;
                tgt_reg    <= req_tgt;
                tgt_ok_reg <= req_tgt_ok;
            end
            head_reg    <= head_next;
            fwd_vld_reg <= fwd_vld_next;
            bwd_vld_reg <= bwd_vld_next;
            done_reg    <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rsp_reg.shifted_node <= shifted;
            rsp_reg.is_queued    <= is_q;
            rsp_reg.pending      <= (head_next != '0);
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

`default_nettype wire

// ===== design/dll_checker.sv =====
// ============================================================================
// dll_checker
// Port-level checks for the doubly linked list manager.
// ============================================================================
`default_nettype none

module dll_checker
    import dll_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     done,
    input wire dll_rsp_t result
);

    // result shows only once the request side is free again
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an accepted request keeps the block busy the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("no busy after accept");

    // every strobe follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a request");

    // a shift result and a query hit never come together
    a_excl_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.shifted_node == '0) || !result.is_queued))
        else $error("shift and query result together");

    // the strobe lasts a single cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

endmodule

bind doubly_linked_list_manager_top dll_checker u_dll_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

`default_nettype wire
